// ===== design/fpau_pkg.sv =====
// fpau_pkg: shared types, codes and helpers of the fixed point accumulator with undo
// used by fpau_ctrl, fpau_dp and fixed_point_accumulator_with_undo
package fpau_pkg;

   // history sizing
   localparam int HISTORY_DEPTH = 16;
   localparam int HIST_AW       = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);

   // restoring divider: 32 bits of magnitude shifted up by 16
   localparam int DIV_STEPS = 48;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // operation codes
   localparam logic [2:0] KIND_ADD  = 3'd0;
   localparam logic [2:0] KIND_SUB  = 3'd1;
   localparam logic [2:0] KIND_MUL  = 3'd2;
   localparam logic [2:0] KIND_DIV  = 3'd3;
   localparam logic [2:0] KIND_LOAD = 3'd4;
   localparam logic [2:0] KIND_UNDO = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [1:0] ST_NO_UNDO  = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] operand;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         status;
      logic [4:0]         history_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic stage_simple;
      logic stage_mul;
      logic div_start;
      logic div_step;
      logic stage_div;
      logic stage_undo;
      logic commit;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] kind;
      logic       operand_zero;
      logic       history_empty;
      logic       div_busy;
   } ctl_status_type;

   typedef struct packed {
      logic [31:0] value;
      logic        sat;
   } sat_type;

   // saturate a 48-bit signed value into 32 bits
   function automatic sat_type clamp48(logic signed [47:0] v);
      sat_type r;
      if ((v[47:31] == '0) || (v[47:31] == '1)) begin
         r.value = v[31:0];
         r.sat   = 1'b0;
      end else begin
         r.value = v[47] ? 32'h8000_0000 : 32'h7fff_ffff;
         r.sat   = 1'b1;
      end
      return r;
   endfunction

   // fill count shown on the 5-bit history_count field
   function automatic logic [4:0] count_out(logic [FILL_W-1:0] f);
      logic [FILL_W+4:0] w;
      w = {5'b0, f};
      return w[4:0];
   endfunction

endpackage

// ===== design/fixed_point_accumulator_with_undo.sv =====
// fixed_point_accumulator_with_undo: top level of the Q16.16 accumulator with undo history
// depends on fpau_pkg, fpau_ctrl, fpau_dp (which holds fpau_ram)

// A signed Q16.16 accumulator that takes one operation per transaction (add,
// subtract, multiply, divide, load, undo) and returns one result transaction
// with the new accumulator value, a status code and the number of values left
// to undo. Every operation that changes the accumulator saves the old value in
// a circular history of fpau_pkg::HISTORY_DEPTH entries, dropping the oldest
// when full; undo restores the newest. Arithmetic saturates with overflow
// status, divide by zero and undo on an empty history leave the state alone.
// One transaction is worked on at a time. Add, subtract, load, unused codes
// and the error cases are staged straight from the captured request; multiply
// waits for a registered 32x32 multiplier, undo for the registered read of the
// history ram, and divide for the restoring divider, which produces one of its
// 48 quotient bits per cycle. A new request is taken in the cycle
// after the result is registered, even while that result still waits in the
// output register; the block then stalls before its own commit until the
// output register is free. No clearing pass runs after reset.

module fixed_point_accumulator_with_undo (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  fpau_pkg::req_type req_data,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fpau_pkg::rsp_type rsp_data
);
   // command and status between sequencer and datapath
   fpau_pkg::ctl_cmd_type    cmd;
   fpau_pkg::ctl_status_type sts;

   // sequencer: accept, dispatch by operation, iterate divide, commit
   fpau_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   // datapath: accumulator, arithmetic units, history ram, output register
   fpau_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_data(req_data),
      .rsp_data(rsp_data),
      .cmd     (cmd),
      .sts     (sts)
   );
endmodule

// ===== design/fpau_ram.sv =====
// fpau_ram: generic single-write, single-read ram with registered read data
// no dependencies
module fpau_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  logic [WIDTH-1:0]       wr_data,
   input  logic [AW-1:0]          rd_addr,
   output logic [WIDTH-1:0]       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/fpau_ctrl.sv =====
// fpau_ctrl: sequencing state machine of the accumulator
// depends on fpau_pkg (command and status structs, operation codes)
module fpau_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  fpau_pkg::ctl_status_type sts,
   output fpau_pkg::ctl_cmd_type    cmd
);
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_UNDO   = 3'd4;
   localparam logic [2:0] S_COMMIT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (sts.kind)
               fpau_pkg::KIND_MUL: begin
                  state_in = S_MUL;
               end
               fpau_pkg::KIND_DIV: begin
                  if (sts.operand_zero) begin
                     cmd.stage_simple = 1'b1;
                     state_in         = S_COMMIT;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in      = S_DIV;
                  end
               end
               fpau_pkg::KIND_UNDO: begin
                  if (sts.history_empty) begin
                     cmd.stage_simple = 1'b1;
                     state_in         = S_COMMIT;
                  end else begin
                     state_in = S_UNDO;
                  end
               end
               default: begin
                  cmd.stage_simple = 1'b1;
                  state_in         = S_COMMIT;
               end
            endcase
         end
         S_MUL: begin
            cmd.stage_mul = 1'b1;
            state_in      = S_COMMIT;
         end
         S_DIV: begin
            if (sts.div_busy) begin
               cmd.div_step = 1'b1;
            end else begin
               cmd.stage_div = 1'b1;
               state_in      = S_COMMIT;
            end
         end
         S_UNDO: begin
            cmd.stage_undo = 1'b1;
            state_in       = S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ===== design/fpau_dp.sv =====
// fpau_dp: accumulator datapath with adder, multiplier, restoring divider and history
// depends on fpau_pkg and fpau_ram
module fpau_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  fpau_pkg::req_type        req_data,
   output fpau_pkg::rsp_type        rsp_data,
   input  fpau_pkg::ctl_cmd_type    cmd,
   output fpau_pkg::ctl_status_type sts
);
   localparam logic [fpau_pkg::HIST_AW-1:0] HIST_LAST =
      fpau_pkg::HIST_AW'(fpau_pkg::HISTORY_DEPTH - 1);
   localparam logic [fpau_pkg::FILL_W-1:0] FILL_FULL =
      fpau_pkg::FILL_W'(fpau_pkg::HISTORY_DEPTH);

   // captured transaction
   logic [2:0]         kind_ff;
   logic signed [31:0] opd_ff;

   // architectural state
   logic signed [31:0]            acc_ff, acc_in;
   logic [fpau_pkg::HIST_AW-1:0]  top_ff, top_in;
   logic [fpau_pkg::FILL_W-1:0]   fill_ff, fill_in;

   // staged result
   logic [31:0] res_value_ff;
   logic [1:0]  res_status_ff;
   logic        res_push_ff;
   logic        res_pop_ff;

   // multiplier register
   logic signed [63:0] prod_ff;

   // divider
   logic [47:0]                     dvd_ff;
   logic [31:0]                     dvs_ff;
   logic [31:0]                     rem_ff;
   logic [47:0]                     quo_ff;
   logic                            neg_ff;
   logic [fpau_pkg::DIV_CNT_W-1:0]  cnt_ff;

   fpau_pkg::rsp_type rsp_ff;

   logic [fpau_pkg::HIST_AW-1:0] top_inc, top_dec;
   logic [31:0]                  ram_rdata;
   logic                         ram_wr;

   fpau_pkg::sat_type sum_sat, diff_sat, mul_sat;
   logic signed [32:0] sum_w, diff_w;
   logic [32:0]        neg_acc, neg_opd;
   logic [31:0]        mag_a, mag_b;
   logic [32:0]        shifted;
   logic [33:0]        trial;
   logic               trial_ge;
   logic [47:0]        quo_neg;

   assign top_inc = (top_ff == HIST_LAST) ? '0 : top_ff + 1'b1;
   assign top_dec = (top_ff == '0) ? HIST_LAST : top_ff - 1'b1;

   assign sts.kind          = kind_ff;
   assign sts.operand_zero  = (opd_ff == '0);
   assign sts.history_empty = (fill_ff == '0);
   assign sts.div_busy      = (cnt_ff != '0);

   // add and subtract with saturation
   assign sum_w    = {acc_ff[31], acc_ff} + {opd_ff[31], opd_ff};
   assign diff_w   = {acc_ff[31], acc_ff} - {opd_ff[31], opd_ff};
   assign sum_sat  = fpau_pkg::clamp48({{15{sum_w[32]}}, sum_w});
   assign diff_sat = fpau_pkg::clamp48({{15{diff_w[32]}}, diff_w});

   // product floored by the arithmetic shift
   assign mul_sat = fpau_pkg::clamp48(prod_ff[63:16]);

   // magnitudes for the divider (the most negative value maps to 2^31)
   assign neg_acc = 33'd0 - {acc_ff[31], acc_ff};
   assign neg_opd = 33'd0 - {opd_ff[31], opd_ff};
   assign mag_a   = acc_ff[31] ? neg_acc[31:0] : acc_ff;
   assign mag_b   = opd_ff[31] ? neg_opd[31:0] : opd_ff;

   // one quotient bit per step
   assign shifted  = {rem_ff, dvd_ff[47]};
   assign trial    = {1'b0, shifted} - {2'b0, dvs_ff};
   assign trial_ge = !trial[33];
   assign quo_neg  = 48'd0 - quo_ff;

   always_ff @(posedge clock) begin
      prod_ff <= acc_ff * opd_ff;
      if (cmd.capture) begin
         kind_ff <= req_data.kind;
         opd_ff  <= req_data.operand;
      end
      if (cmd.div_start) begin
         dvd_ff <= {mag_a, 16'b0};
         dvs_ff <= mag_b;
         rem_ff <= '0;
         quo_ff <= '0;
         neg_ff <= acc_ff[31] ^ opd_ff[31];
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[46:0], 1'b0};
         rem_ff <= trial_ge ? trial[31:0] : shifted[31:0];
         quo_ff <= {quo_ff[46:0], trial_ge};
      end
      if (cmd.stage_simple) begin
         case (kind_ff)
            fpau_pkg::KIND_ADD: begin
               res_value_ff  <= sum_sat.value;
               res_status_ff <= sum_sat.sat ? fpau_pkg::ST_OVERFLOW : fpau_pkg::ST_OK;
               res_push_ff   <= 1'b1;
               res_pop_ff    <= 1'b0;
            end
            fpau_pkg::KIND_SUB: begin
               res_value_ff  <= diff_sat.value;
               res_status_ff <= diff_sat.sat ? fpau_pkg::ST_OVERFLOW : fpau_pkg::ST_OK;
               res_push_ff   <= 1'b1;
               res_pop_ff    <= 1'b0;
            end
            fpau_pkg::KIND_LOAD: begin
               res_value_ff  <= opd_ff;
               res_status_ff <= fpau_pkg::ST_OK;
               res_push_ff   <= 1'b1;
               res_pop_ff    <= 1'b0;
            end
            fpau_pkg::KIND_DIV: begin
               res_value_ff  <= acc_ff;
               res_status_ff <= fpau_pkg::ST_DIV_ZERO;
               res_push_ff   <= 1'b0;
               res_pop_ff    <= 1'b0;
            end
            fpau_pkg::KIND_UNDO: begin
               res_value_ff  <= acc_ff;
               res_status_ff <= fpau_pkg::ST_NO_UNDO;
               res_push_ff   <= 1'b0;
               res_pop_ff    <= 1'b0;
            end
            default: begin
               res_value_ff  <= acc_ff;
               res_status_ff <= fpau_pkg::ST_OK;
               res_push_ff   <= 1'b0;
               res_pop_ff    <= 1'b0;
            end
         endcase
      end else if (cmd.stage_mul) begin
         res_value_ff  <= mul_sat.value;
         res_status_ff <= mul_sat.sat ? fpau_pkg::ST_OVERFLOW : fpau_pkg::ST_OK;
         res_push_ff   <= 1'b1;
         res_pop_ff    <= 1'b0;
      end else if (cmd.stage_div) begin
         res_push_ff <= 1'b1;
         res_pop_ff  <= 1'b0;
         if (neg_ff) begin
            if (quo_ff > 48'h0000_8000_0000) begin
               res_value_ff  <= 32'h8000_0000;
               res_status_ff <= fpau_pkg::ST_OVERFLOW;
            end else begin
               res_value_ff  <= quo_neg[31:0];
               res_status_ff <= fpau_pkg::ST_OK;
            end
         end else begin
            if (quo_ff > 48'h0000_7fff_ffff) begin
               res_value_ff  <= 32'h7fff_ffff;
               res_status_ff <= fpau_pkg::ST_OVERFLOW;
            end else begin
               res_value_ff  <= quo_ff[31:0];
               res_status_ff <= fpau_pkg::ST_OK;
            end
         end
      end else if (cmd.stage_undo) begin
         res_value_ff  <= ram_rdata;
         res_status_ff <= fpau_pkg::ST_OK;
         res_push_ff   <= 1'b0;
         res_pop_ff    <= 1'b1;
      end
      if (cmd.commit) begin
         rsp_ff.value         <= res_value_ff;
         rsp_ff.status        <= res_status_ff;
         rsp_ff.history_count <= fpau_pkg::count_out(fill_in);
      end
   end

   // commit: push the old value or pop the newest one
   always_comb begin
      acc_in  = acc_ff;
      top_in  = top_ff;
      fill_in = fill_ff;
      if (cmd.commit) begin
         acc_in = res_value_ff;
         if (res_push_ff) begin
            top_in  = top_inc;
            fill_in = (fill_ff == FILL_FULL) ? fill_ff : fill_ff + 1'b1;
         end else if (res_pop_ff) begin
            top_in  = top_dec;
            fill_in = fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         top_ff  <= '0;
         fill_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         acc_ff  <= acc_in;
         top_ff  <= top_in;
         fill_ff <= fill_in;
         if (cmd.div_start) begin
            cnt_ff <= fpau_pkg::DIV_CNT_W'(fpau_pkg::DIV_STEPS);
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   assign ram_wr = cmd.commit && res_push_ff;

   fpau_ram #(
      .WIDTH(32),
      .DEPTH(fpau_pkg::HISTORY_DEPTH)
   ) u_hist (
      .clock  (clock),
      .wr_en  (ram_wr),
      .wr_addr(top_ff),
      .wr_data(acc_ff),
      .rd_addr(top_dec),
      .rd_data(ram_rdata)
   );

   assign rsp_data = rsp_ff;
endmodule
